/* sv/cdp_pkg.sv */
package cdp_pkg;

	typedef enum logic [1:0] {
		MODE_STARTUP = 2'd0,
		MODE_SETTLE  = 2'd1,
		MODE_WAIT    = 2'd2,
		MODE_TRACK   = 2'd3
	} loop_mode_t;

	typedef enum logic [2:0] {
		CFG_PROP_GAIN   = 3'd0,
		CFG_INT_DIVISOR = 3'd1,
		CFG_CAPTURE     = 3'd2,
		CFG_GAIN_FLOOR  = 3'd3,
		CFG_STIFFEN     = 3'd4
	} cfg_index_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_MODE,
		S_DIV,
		S_DIV_END,
		S_PW_INT,
		S_PW_ACCI,
		S_PW_SQ,
		S_PW_FRAC,
		S_SQRT,
		S_PW_FB,
		S_PW_ACCF,
		S_GA,
		S_GA_DONE,
		S_GB_DONE,
		S_PM,
		S_PM_DONE,
		S_IM_DONE,
		S_LIM_DONE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_FIN
	} state_t;

	localparam logic [31:0] RST_PROP_GAIN   = 32'd1417339208;
	localparam logic [15:0] RST_INT_DIVISOR = 16'd60;
	localparam logic [15:0] RST_CAPTURE     = 16'd300;
	localparam logic [31:0] RST_GAIN_FLOOR  = 32'd128849019;
	localparam logic [31:0] RST_STIFFEN     = 32'd4290672329;

	localparam logic [47:0] STEP_THRESHOLD = 48'd1099511628;
	localparam logic [47:0] MAX48          = 48'h7FFF_FFFF_FFFF;
	localparam logic [31:0] LOW_A          = 32'd128849019;
	localparam logic [31:0] LOW_B          = 32'd2147484;
	localparam logic [31:0] MID_A          = 32'd257698038;
	localparam logic [31:0] MID_B          = 32'd4294967;
	localparam logic [31:0] CLAMP_PER_SEC  = 32'd549755814;
	localparam logic [15:0] WEIGHT_SETTLE  = 16'd3;
	localparam logic [15:0] WEIGHT_LOW     = 16'd50;
	localparam logic [15:0] WEIGHT_HIGH    = 16'd150;
	localparam logic [63:0] SETTLE_TIME    = 64'd2 << 32;
	localparam logic [63:0] WAIT_TIME      = 64'd6 << 32;

endpackage

/* sv/clock_discipline_pll.sv */
// Channel | Handshake              | Payload
// in      | in_valid / in_ready    | sample_time, phase_offset, sample_weight, timebase_epoch
// out     | out_valid / out_ready  | loop_mode, step_request, step_amount, adjust_request,
//         |                        | phase_correction, slew_seconds, freq_correction
// cfg     | cfg_we                 | cfg_index, cfg_data
//
// One transaction at a time; in_ready is low from acceptance until the result is loaded.
// Startup and settle go straight to the result. Wait entry runs a 32-step divider. Tracking
// uses the shared 32x32 multiplier (steps S_MUL0, S_MUL1, S_MUL2); stiffening adds a
// power loop over the integer bits of dt and a bit-serial square root for its fraction
// bits.
// Async reset clears mode, gains, integrator, times and loads register defaults.
// A waiting result sits in the output register; the next transaction is taken meanwhile.
module clock_discipline_pll (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [63:0]         sample_time,
	input  logic signed [47:0]  phase_offset,
	input  logic [15:0]         sample_weight,
	input  logic [15:0]         timebase_epoch,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          loop_mode,
	output logic                step_request,
	output logic signed [47:0]  step_amount,
	output logic                adjust_request,
	output logic signed [47:0]  phase_correction,
	output logic [15:0]         slew_seconds,
	output logic signed [47:0]  freq_correction,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import cdp_pkg::*;

	state_t state_q, state_d, ret_q;

	logic [31:0] cfg_gain_q, cfg_floor_q, cfg_rate_q;
	logic [15:0] cfg_div_q, cfg_cap_q;

	loop_mode_t mode_q;
	logic signed [47:0] integ_q;
	logic [31:0] ga_q, gb_q;
	logic [63:0] epoch_q, prev_q;
	logic [15:0] seen_q;

	logic [63:0] t_q;
	logic [47:0] mag_q;
	logic        neg_q;
	logic [15:0] w_q, gen_q;

	logic        step_req_q, adj_q;
	logic [47:0] step_amt_q, phase_q;
	logic [15:0] slew_q, dur_q;
	logic [31:0] ua_q, ub_q;
	logic        use_gain_q;
	logic [47:0] pmag_q;

	logic [31:0] n_q, f_q, p_q, r_q;
	logic [32:0] acc_q;
	logic [63:0] sv_q, sres_q, sbit_q;
	logic [31:0] dq_q;
	logic [15:0] rem_q;
	logic [4:0]  cnt_q;

	logic [63:0] mul_a_q;
	logic [31:0] mul_b_q;
	logic [63:0] prod_q;
	logic [95:0] mres_q;

	logic        ov_q;
	logic [1:0]  o_mode_q;
	logic        o_step_q, o_adj_q;
	logic [47:0] o_step_amt_q, o_phase_q, o_freq_q;
	logic [15:0] o_slew_q;

	// combinational helpers
	loop_mode_t mode_eff;
	logic [63:0] d_epoch, d_prev, dt;
	logic        settle_ok, wait_ok, cap_ok, stiffen;
	logic [32:0] dur_raw;
	logic [15:0] dur;
	logic [15:0] div_eff;
	logic [16:0] trial;
	logic [63:0] sq_sum;
	logic [31:0] ua_eff, ub_eff;
	logic [55:0] imag;
	logic signed [57:0] isum;
	logic [47:0] lim, cmag;
	logic        fin_go;

	always_comb begin
		mode_eff  = (gen_q != seen_q) ? MODE_STARTUP : mode_q;
		d_epoch   = t_q - epoch_q;
		d_prev    = t_q - prev_q;
		dt        = d_prev[63] ? 64'd0 : d_prev;
		settle_ok = !d_epoch[63] && (d_epoch > SETTLE_TIME) && (w_q > WEIGHT_SETTLE);
		wait_ok   = !d_epoch[63] && (d_epoch > WAIT_TIME);
		cap_ok    = !d_epoch[63] && (d_epoch > {16'd0, cfg_cap_q, 32'd0});
		stiffen   = (w_q >= WEIGHT_HIGH) && cap_ok && (ga_q > cfg_floor_q);
		dur_raw   = {1'b0, dt[63:32]} + {32'd0, |dt[31:0]};
		dur       = (dur_raw > 33'd65535) ? 16'hFFFF : dur_raw[15:0];
		div_eff   = (cfg_div_q == 16'd0) ? 16'd1 : cfg_div_q;
		trial     = {rem_q, dq_q[31]};
		sq_sum    = sres_q + sbit_q;
		ua_eff    = use_gain_q ? ga_q : ua_q;
		ub_eff    = use_gain_q ? gb_q : ub_q;
		imag      = mres_q[79:24];
		// p is negative when the offset is positive
		isum      = {{10{integ_q[47]}}, integ_q} +
		            (neg_q ? $signed({2'b00, imag}) : -$signed({2'b00, imag}));
		lim       = mres_q[47:0];
		cmag      = (pmag_q < lim) ? pmag_q : lim;
		fin_go    = !ov_q || out_ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (in_valid) state_d = S_MODE;
			S_MODE: begin
				case (mode_eff)
					MODE_WAIT:  state_d = wait_ok ? S_DIV : S_FIN;
					MODE_TRACK: state_d = stiffen ? S_PW_INT : S_PM;
					default:    state_d = S_FIN;
				endcase
			end
			S_DIV:     if (cnt_q == 5'd31) state_d = S_DIV_END;
			S_DIV_END: state_d = S_FIN;
			S_PW_INT:  state_d = (n_q == 32'd0) ? S_PW_FRAC : S_MUL0;
			S_PW_ACCI: state_d = S_PW_INT;
			S_PW_SQ:   state_d = S_PW_INT;
			S_PW_FRAC: state_d = (f_q == 32'd0) ? S_GA : S_SQRT;
			S_SQRT:    if (cnt_q == 5'd31) state_d = S_PW_FB;
			S_PW_FB:   state_d = f_q[31] ? S_MUL0 : S_PW_FRAC;
			S_PW_ACCF: state_d = S_PW_FRAC;
			S_GA:      state_d = S_MUL0;
			S_GA_DONE: state_d = S_MUL0;
			S_GB_DONE: state_d = S_PM;
			S_PM:      state_d = S_MUL0;
			S_PM_DONE: state_d = S_MUL0;
			S_IM_DONE: state_d = S_MUL0;
			S_LIM_DONE: state_d = S_FIN;
			S_MUL0:    state_d = S_MUL1;
			S_MUL1:    state_d = S_MUL2;
			S_MUL2:    state_d = ret_q;
			S_FIN:     if (fin_go) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready         = (state_q == S_IDLE);
		out_valid        = ov_q;
		loop_mode        = o_mode_q;
		step_request     = o_step_q;
		step_amount      = o_step_amt_q;
		adjust_request   = o_adj_q;
		phase_correction = o_phase_q;
		slew_seconds     = o_slew_q;
		freq_correction  = o_freq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cfg_gain_q  <= RST_PROP_GAIN;
			cfg_div_q   <= RST_INT_DIVISOR;
			cfg_cap_q   <= RST_CAPTURE;
			cfg_floor_q <= RST_GAIN_FLOOR;
			cfg_rate_q  <= RST_STIFFEN;
			mode_q      <= MODE_STARTUP;
			integ_q     <= '0;
			ga_q        <= '0;
			gb_q        <= '0;
			epoch_q     <= '0;
			prev_q      <= '0;
			seen_q      <= '0;
			ov_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_PROP_GAIN:   cfg_gain_q  <= cfg_data;
					CFG_INT_DIVISOR: cfg_div_q   <= cfg_data[15:0];
					CFG_CAPTURE:     cfg_cap_q   <= cfg_data[15:0];
					CFG_GAIN_FLOOR:  cfg_floor_q <= cfg_data;
					CFG_STIFFEN:     cfg_rate_q  <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_FIN && fin_go)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
			case (state_q)
				S_MODE: begin
					seen_q <= gen_q;
					prev_q <= t_q;
					case (mode_eff)
						MODE_STARTUP: begin
							epoch_q <= t_q;
							mode_q  <= MODE_SETTLE;
							ga_q    <= cfg_gain_q;
							gb_q    <= '0;
						end
						MODE_SETTLE: begin
							if (settle_ok) begin
								mode_q  <= MODE_WAIT;
								epoch_q <= t_q;
							end
						end
						default: mode_q <= mode_eff;
					endcase
				end
				S_DIV_END: begin
					gb_q    <= dq_q;
					epoch_q <= t_q;
					mode_q  <= MODE_TRACK;
				end
				S_GA_DONE: ga_q <= mres_q[63:32];
				S_GB_DONE: gb_q <= mres_q[63:32];
				S_IM_DONE: begin
					if (isum > 58'sh0_7FFF_FFFF_FFFF)
						integ_q <= $signed(MAX48);
					else if (isum < -58'sh0_8000_0000_0000)
						integ_q <= 48'sh8000_0000_0000;
					else
						integ_q <= isum[47:0];
				end
				S_FIN: begin
					if (fin_go) begin
						o_mode_q     <= mode_q;
						o_step_q     <= step_req_q;
						o_step_amt_q <= step_amt_q;
						o_adj_q      <= adj_q;
						o_phase_q    <= phase_q;
						o_slew_q     <= slew_q;
						o_freq_q     <= integ_q;
					end
				end
				default: ;
			endcase
		end
	end

	// working datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					t_q        <= sample_time;
					neg_q      <= phase_offset[47];
					mag_q      <= phase_offset[47] ? -phase_offset : phase_offset;
					w_q        <= sample_weight;
					gen_q      <= timebase_epoch;
					step_req_q <= 1'b0;
					step_amt_q <= '0;
					adj_q      <= 1'b0;
					phase_q    <= '0;
					slew_q     <= '0;
				end
			end
			S_MODE: begin
				case (mode_eff)
					MODE_SETTLE: begin
						if (settle_ok && mag_q >= STEP_THRESHOLD) begin
							step_req_q <= 1'b1;
							if (neg_q)
								step_amt_q <= (mag_q > MAX48) ? MAX48 : mag_q;
							else
								step_amt_q <= -mag_q;
						end
					end
					MODE_WAIT: begin
						dq_q  <= ga_q;
						rem_q <= '0;
						cnt_q <= '0;
					end
					MODE_TRACK: begin
						dur_q      <= dur;
						use_gain_q <= 1'b0;
						if (w_q < WEIGHT_LOW) begin
							ua_q <= LOW_A;
							ub_q <= LOW_B;
						end else if (w_q < WEIGHT_HIGH) begin
							ua_q <= MID_A;
							ub_q <= MID_B;
						end else begin
							use_gain_q <= 1'b1;
						end
						n_q   <= dt[63:32];
						f_q   <= dt[31:0];
						p_q   <= cfg_rate_q;
						r_q   <= cfg_rate_q;
						acc_q <= 33'h1_0000_0000;
					end
					default: ;
				endcase
			end
			S_DIV: begin
				if (trial >= {1'b0, div_eff}) begin
					rem_q <= 16'(trial - {1'b0, div_eff});
					dq_q  <= {dq_q[30:0], 1'b1};
				end else begin
					rem_q <= trial[15:0];
					dq_q  <= {dq_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
			end
			S_PW_INT: begin
				if (n_q != 32'd0) begin
					mul_b_q <= p_q;
					if (n_q[0]) begin
						mul_a_q <= {31'd0, acc_q};
						ret_q   <= S_PW_ACCI;
					end else begin
						mul_a_q <= {32'd0, p_q};
						ret_q   <= S_PW_SQ;
					end
				end
			end
			S_PW_ACCI: begin
				acc_q  <= mres_q[64:32];
				n_q[0] <= 1'b0;
			end
			S_PW_SQ: begin
				p_q <= mres_q[63:32];
				n_q <= n_q >> 1;
			end
			S_PW_FRAC: begin
				sv_q   <= {r_q, 32'd0};
				sres_q <= '0;
				sbit_q <= 64'd1 << 62;
				cnt_q  <= '0;
			end
			S_SQRT: begin
				if (sv_q >= sq_sum) begin
					sv_q   <= sv_q - sq_sum;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
				cnt_q  <= cnt_q + 5'd1;
			end
			S_PW_FB: begin
				r_q <= sres_q[31:0];
				if (f_q[31]) begin
					mul_a_q <= {31'd0, acc_q};
					mul_b_q <= sres_q[31:0];
					ret_q   <= S_PW_ACCF;
				end else begin
					f_q <= f_q << 1;
				end
			end
			S_PW_ACCF: begin
				acc_q <= mres_q[64:32];
				f_q   <= f_q << 1;
			end
			S_GA: begin
				mul_a_q <= {31'd0, acc_q};
				mul_b_q <= ga_q;
				ret_q   <= S_GA_DONE;
			end
			S_GA_DONE: begin
				mul_a_q <= {31'd0, acc_q};
				mul_b_q <= gb_q;
				ret_q   <= S_GB_DONE;
			end
			S_PM: begin
				mul_a_q <= {16'd0, mag_q};
				mul_b_q <= ua_eff;
				ret_q   <= S_PM_DONE;
			end
			S_PM_DONE: begin
				pmag_q  <= mres_q[79:32];
				mul_a_q <= {16'd0, mres_q[79:32]};
				mul_b_q <= ub_eff;
				ret_q   <= S_IM_DONE;
			end
			S_IM_DONE: begin
				mul_a_q <= {48'd0, dur_q};
				mul_b_q <= CLAMP_PER_SEC;
				ret_q   <= S_LIM_DONE;
			end
			S_LIM_DONE: begin
				if (dur_q != 16'd0) begin
					adj_q   <= 1'b1;
					phase_q <= neg_q ? cmag : -cmag;
					slew_q  <= dur_q;
				end
			end
			// shared multiplier: two 32x32 partial products, registered, then summed
			S_MUL0: prod_q <= mul_a_q[31:0] * mul_b_q;
			S_MUL1: begin
				mres_q <= {32'd0, prod_q};
				prod_q <= mul_a_q[63:32] * mul_b_q;
			end
			S_MUL2: mres_q <= mres_q + {prod_q, 32'd0};
			default: ;
		endcase
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a transaction while busy");

	a_step_adj_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(step_request && adjust_request))
		else $error("step and adjustment in one result");

	a_adj_track: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && adjust_request |-> slew_seconds != 16'd0 && loop_mode == MODE_TRACK)
		else $error("adjustment outside tracking or without slew");

	a_step_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_request |-> loop_mode == MODE_WAIT)
		else $error("step request outside settle exit");

endmodule
